// ----- hw/rtl/fsla_pkg.sv -----
// Shared types and constants for the free-list slot allocator.
// No dependencies; imported by the top level.
package fsla_pkg;

  // Operation codes carried on the kind port.
  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // Control sequencer, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ALLOC = 3'b010,
    ST_INIT  = 3'b100
  } state_t;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [8:0] ELEM_COUNT_RESET = 9'd256;

endpackage

// ----- hw/rtl/fsla_link_ram.sv -----
// Link memory of the free-list allocator: one write port, one read port.
// Read data is registered. No dependencies.
module fsla_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/free_list_slot_allocator.sv -----
// Free-list slot allocator top level: sequencer, head and count registers.
// Depends on fsla_pkg and fsla_link_ram.
//
// A pool of MAX_SLOTS slots is kept as a LIFO list of free slots; each slot
// holds one link in an on-chip link memory and the block keeps the head. A
// command is taken when start is high and busy is low, and every command gives
// exactly one result beat: done pulses high for one cycle with granted_index
// and status, and used_count shows the count after that command. The receiver
// cannot stall, so sample the result in the done cycle. Free, unknown kind and
// allocate on an empty list give their result straight from the idle state;
// allocate on a non-empty list passes through ST_ALLOC, as the link memory read
// is registered (read the head's link on accept, then pop in ST_ALLOC); init
// walks ST_INIT over n = min(element_count, MAX_SLOTS) slots, since the single
// write port links one slot per cycle (n = 0 stays in the idle state). The link
// memory needs no clearing after reset; the list reads as empty until the first
// init or free. element_count is written through element_count_we while the
// block is idle; the user must keep to this, the block does not enforce it.
module free_list_slot_allocator #(
  parameter int MAX_SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] slot_index,
  // configuration
  input  logic       element_count_we,
  input  logic [8:0] element_count,
  // result channel
  output logic       done,
  output logic [7:0] granted_index,
  output logic       status,
  output logic [8:0] used_count
);

  import fsla_pkg::*;

  // link width holds every slot index plus the end marker (MAX_SLOTS)
  localparam int AW = $clog2(MAX_SLOTS);
  localparam int LW = $clog2(MAX_SLOTS + 1);
  localparam logic [LW-1:0] LINK_END = LW'(MAX_SLOTS);

  state_t               state;
  logic [LW-1:0]        head;
  logic [COUNT_W-1:0]   count;
  logic [8:0]           elem_count;
  logic [AW-1:0]        init_idx;
  logic [LW-1:0]        init_last;
  logic [7:0]           granted;
  logic                 oom;

  logic                 accept;
  kind_t                kind_c;
  logic                 head_empty;
  logic                 slot_ok;
  logic [LW-1:0]        init_n;
  logic [COUNT_W-1:0]   count_inc;
  logic [COUNT_W-1:0]   count_dec;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [LW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [LW-1:0]        ram_rdata;

  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign kind_c        = kind_t'(kind);
  assign head_empty    = (head >= LINK_END);
  assign slot_ok       = (32'(slot_index) < 32'(MAX_SLOTS));
  assign init_n        = (32'(elem_count) > 32'(MAX_SLOTS)) ? LINK_END : LW'(elem_count);
  assign count_inc     = (count == COUNT_MAX) ? count : count + 1'b1;
  assign count_dec     = (count == '0) ? count : count - 1'b1;
  assign granted_index = granted;
  assign status        = oom;
  assign used_count    = count;

  // Link memory port control. Only one command is in flight, so a read never
  // overlaps a write to the same entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = init_idx;
    ram_wdata = LINK_END;
    ram_re    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind_c == KIND_FREE && slot_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(slot_index);
          ram_wdata = head;
        end
        ram_re = accept && kind_c == KIND_ALLOC && !head_empty;
      end
      ST_ALLOC: begin
        // popped slot's link goes back to the end marker
        ram_we    = 1'b1;
        ram_waddr = head[AW-1:0];
        ram_wdata = LINK_END;
      end
      ST_INIT: begin
        // slot i links to slot i-1, slot 0 ends the list
        ram_we    = 1'b1;
        ram_waddr = init_idx;
        ram_wdata = (init_idx == '0) ? LINK_END : LW'(init_idx) - 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fsla_link_ram #(
    .DEPTH(MAX_SLOTS),
    .WIDTH(LW)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(head[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Result payload: granted index and out-of-memory flag.
  always_ff @(posedge clk) begin
    if (state == ST_ALLOC) begin
      granted <= 8'(head);
      oom     <= 1'b0;
    end else if (accept) begin
      granted <= '0;
      oom     <= (kind_c == KIND_ALLOC) && head_empty;
    end
  end

  // Init walk bounds.
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      init_idx <= init_idx + 1'b1;
    end else if (accept) begin
      init_idx  <= '0;
      init_last <= init_n - 1'b1;
    end
  end

  // Sequencer, head, count, config register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= LINK_END;
      count      <= '0;
      elem_count <= ELEM_COUNT_RESET;
      done       <= 1'b0;
    end else begin
      if (element_count_we) begin
        elem_count <= element_count;
      end
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind_c)
              KIND_INIT: begin
                if (init_n == '0) begin
                  head  <= LINK_END;
                  count <= '0;
                  done  <= 1'b1;
                end else begin
                  state <= ST_INIT;
                end
              end
              KIND_ALLOC: begin
                if (head_empty) begin
                  done <= 1'b1;
                end else begin
                  state <= ST_ALLOC;
                end
              end
              KIND_FREE: begin
                if (slot_ok) begin
                  head  <= LW'(slot_index);
                  count <= count_dec;
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_ALLOC: begin
          // stray link values collapse to the end marker
          head  <= (ram_rdata >= LINK_END) ? LINK_END : ram_rdata;
          count <= count_inc;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_INIT: begin
          if (LW'(init_idx) == init_last) begin
            head  <= init_last;
            count <= '0;
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A pop only happens from a non-empty list.
  a_alloc_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_ALLOC |-> !head_empty)
    else $error("pop issued with empty list");

  // The pop state is always followed by idle.
  a_alloc_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_ALLOC |=> state == ST_IDLE)
    else $error("pop step did not finish");

  // No result beat while a command is still in progress.
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !done)
    else $error("result beat while busy");

  // Out of memory never hands out an index.
  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> granted_index == 8'd0)
    else $error("index granted on out of memory");

  // Every result beat follows an accept or the end of a multi-cycle step.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept) || $past(state == ST_ALLOC) || $past(state == ST_INIT))
    else $error("result beat without a command");

endmodule

// ----- tb/sv/free_list_slot_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for free_list_slot_allocator: directed table, full pool, then random phases.
// Depends on fsla_pkg and the allocator RTL; needs no other files.
module free_list_slot_allocator_test;
  import fsla_pkg::*;

  localparam int POOL_SLOTS = 256;
  localparam logic [8:0] LINK_NIL = 9'd256;   // end-of-list marker in link and head
  localparam int ITEM_TARGET = 700;
  localparam int FILL_FREES = 40;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 300;         // covers a full 256-slot init walk
  localparam int REPORT_LIMIT = 10;

  // One result beat, field for field as it leaves the block.
  typedef struct packed {
    logic [7:0] grant;
    logic       oom;
    logic [8:0] count;
  } alloc_result_t;

  // Directed step: either an element_count write or one command, optionally with
  // a hand-typed expectation.
  typedef struct packed {
    logic          cfg_write;
    logic [8:0]    cfg_value;
    kind_t         op;
    logic [7:0]    slot;
    logic          typed;
    alloc_result_t want;
  } step_row_t;

  localparam int N_STEPS = 29;
  localparam step_row_t STEPS [N_STEPS] = '{
    // before any init the list is empty
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd0,   1'b1, 9'd0}},
    // free before init: pushed, count stays at zero
    '{1'b0, 9'd0,   KIND_FREE,  8'hFF, 1'b1, '{8'd0,   1'b0, 9'd0}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd255, 1'b0, 9'd1}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd0,   1'b1, 9'd1}},
    '{1'b0, 9'd0,   KIND_NOP,   8'hAA, 1'b1, '{8'd0,   1'b0, 9'd1}},
    // init at reset element_count
    '{1'b0, 9'd0,   KIND_INIT,  8'h55, 1'b1, '{8'd0,   1'b0, 9'd0}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd255, 1'b0, 9'd1}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd254, 1'b0, 9'd2}},
    // double free of a slot still on the list
    '{1'b0, 9'd0,   KIND_FREE,  8'h00, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'hFF, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h0F, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_FREE,  8'hAA, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_FREE,  8'h55, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_NOP,   8'hFF, 1'b0, '0},
    // single-slot pool
    '{1'b1, 9'd1,   KIND_NOP,   8'h00, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_INIT,  8'h00, 1'b1, '{8'd0,   1'b0, 9'd0}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd0,   1'b0, 9'd1}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd0,   1'b1, 9'd1}},
    '{1'b0, 9'd0,   KIND_FREE,  8'h00, 1'b1, '{8'd0,   1'b0, 9'd0}},
    // empty pool
    '{1'b1, 9'd0,   KIND_NOP,   8'h00, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_INIT,  8'h00, 1'b1, '{8'd0,   1'b0, 9'd0}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd0,   1'b1, 9'd0}},
    // oversized counts clamp to the pool
    '{1'b1, 9'd511, KIND_NOP,   8'h00, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_INIT,  8'h00, 1'b1, '{8'd0,   1'b0, 9'd0}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd255, 1'b0, 9'd1}},
    '{1'b1, 9'd257, KIND_NOP,   8'h00, 1'b0, '0},
    '{1'b0, 9'd0,   KIND_INIT,  8'h00, 1'b1, '{8'd0,   1'b0, 9'd0}},
    '{1'b0, 9'd0,   KIND_ALLOC, 8'h00, 1'b1, '{8'd255, 1'b0, 9'd1}},
    '{1'b0, 9'd0,   KIND_FREE,  8'h80, 1'b0, '0}
  };

  // Extremes of element_count, used for the first random phases.
  localparam int N_EDGE_SIZES = 7;
  localparam logic [8:0] EDGE_SIZES [N_EDGE_SIZES] =
    '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  kind_t      kind;
  logic [7:0] slot_index;
  logic       element_count_we;
  logic [8:0] element_count;
  logic       done;
  logic [7:0] granted_index;
  logic       status;
  logic [8:0] used_count;

  free_list_slot_allocator #(.MAX_SLOTS(POOL_SLOTS)) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (kind),
    .slot_index       (slot_index),
    .element_count_we (element_count_we),
    .element_count    (element_count),
    .done             (done),
    .granted_index    (granted_index),
    .status           (status),
    .used_count       (used_count)
  );

  // Shadow of the allocator: links, head, in-use count and the pool size register.
  logic [8:0] link_shadow [POOL_SLOTS];
  logic [8:0] head_shadow;
  logic [8:0] in_use_shadow;
  logic [8:0] pool_size;

  // Expected result beats, oldest first, and the slots handed out so far
  // (only used to shape frees into well-formed returns).
  alloc_result_t pending_results[$];
  logic [7:0]    held_slots[$];

  int     mismatch_count = 0;
  longint cycle_count = 0;
  int     n_init = 0, n_alloc = 0, n_oom = 0, n_free = 0, n_nop = 0, n_cfg = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the shadow by one accepted command and return its result beat.
  function automatic alloc_result_t apply_command(kind_t op, logic [7:0] slot);
    alloc_result_t r;
    int            n;
    logic [8:0]    nxt;
    r = '0;
    case (op)
      KIND_INIT: begin
        n = (pool_size > POOL_SLOTS) ? POOL_SLOTS : int'(pool_size);
        for (int i = 0; i < n; i++)
          link_shadow[i] = (i == 0) ? LINK_NIL : 9'(i - 1);
        head_shadow = (n == 0) ? LINK_NIL : 9'(n - 1);
        in_use_shadow = '0;
        held_slots.delete();
        n_init++;
      end
      KIND_ALLOC: begin
        n_alloc++;
        if (head_shadow >= POOL_SLOTS) begin
          r.oom = 1'b1;
          n_oom++;
        end else begin
          r.grant = head_shadow[7:0];
          nxt = link_shadow[head_shadow[7:0]];
          link_shadow[head_shadow[7:0]] = LINK_NIL;
          head_shadow = (nxt >= POOL_SLOTS) ? LINK_NIL : nxt;
          if (in_use_shadow < COUNT_MAX) in_use_shadow++;
          held_slots.push_back(r.grant);
        end
      end
      KIND_FREE: begin
        // unchecked push: any slot inside the pool lands on the list
        if (int'(slot) < POOL_SLOTS) begin
          link_shadow[slot] = head_shadow;
          head_shadow = {1'b0, slot};
          if (in_use_shadow > 0) in_use_shadow--;
        end
        n_free++;
      end
      default: n_nop++;
    endcase
    r.count = in_use_shadow;
    return r;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // Present one command after an idle gap and hold it until the block takes it.
  // start stays high after acceptance; the next call either lowers it or reuses it.
  task automatic issue(kind_t op, logic [7:0] slot, int gap, bit typed,
                       alloc_result_t typed_want);
    alloc_result_t r;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    kind <= op;
    slot_index <= slot;
    do @(posedge clk); while (busy);
    r = apply_command(op, slot);
    pending_results.push_back(typed ? typed_want : r);
  endtask

  // Drop start, drain every outstanding beat, then write element_count while idle.
  task automatic set_pool_size(logic [8:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    element_count_we <= 1'b1;
    element_count <= value;
    @(negedge clk);
    element_count_we <= 1'b0;
    pool_size = value;
    n_cfg++;
  endtask

  task automatic issue_free_held(int gap);
    int idx;
    logic [7:0] s;
    idx = $urandom_range(0, held_slots.size() - 1);
    s = held_slots[idx];
    held_slots.delete(idx);
    issue(KIND_FREE, s, gap, 1'b0, '0);
  endtask

  // Result checker: every done beat must match the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst && done) begin
      got = '{granted_index, status, used_count};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result beat: grant=%0d status=%0d count=%0d",
                   $realtime, got.grant, got.oom, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.grant !== want.grant || got.oom !== want.oom || got.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"[%0t] mismatch: grant exp %0d got %0d, ",
                      "status exp %0d got %0d, count exp %0d got %0d"},
                     $realtime, want.grant, got.grant, want.oom, got.oom,
                     want.count, got.count);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [8:0] size;
    int         n_items;
    int         bias;
    int         r;
    int         phase;
    bit         burst;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_NOP;
    slot_index = '0;
    element_count_we = 1'b0;
    element_count = ELEM_COUNT_RESET;

    head_shadow = LINK_NIL;
    in_use_shadow = '0;
    pool_size = ELEM_COUNT_RESET;
    for (int i = 0; i < POOL_SLOTS; i++) link_shadow[i] = '0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed table: empty list, unchecked frees, no-ops, size extremes.
    for (int i = 0; i < N_STEPS; i++) begin
      if (STEPS[i].cfg_write)
        set_pool_size(STEPS[i].cfg_value);
      else
        issue(STEPS[i].op, STEPS[i].slot, draw_gap(1'b0), STEPS[i].typed, STEPS[i].want);
    end

    // Full pool: pop every slot, hit out of memory at 256 in use, then return a
    // handful in random order.
    set_pool_size(9'd256);
    issue(KIND_INIT, 8'($urandom_range(0, 255)), 0, 1'b0, '0);
    for (int i = 0; i <= POOL_SLOTS; i++)
      issue(KIND_ALLOC, 8'($urandom_range(0, 255)), draw_gap(1'($urandom_range(0, 1))),
            1'b0, '0);
    for (int i = 0; i < FILL_FREES; i++)
      issue_free_held(draw_gap(1'($urandom_range(0, 1))));

    // Random phases: a size write (the sender drains first), an init, then a mix
    // of allocs and well-formed frees with some noise. Small pools dominate after
    // the extremes so the list runs dry often.
    phase = 0;
    while (n_init + n_alloc + n_free < ITEM_TARGET) begin
      if (phase < N_EDGE_SIZES)
        size = EDGE_SIZES[phase];
      else if ($urandom_range(0, 7) == 0)
        size = 9'($urandom_range(13, 256));
      else
        size = 9'($urandom_range(1, 12));
      set_pool_size(size);
      burst = ($urandom_range(0, 3) == 0);
      issue(KIND_INIT, 8'($urandom_range(0, 255)), draw_gap(burst), 1'b0, '0);
      n_items = $urandom_range(15, 40);
      bias = $urandom_range(40, 75);
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < bias)
          issue(KIND_ALLOC, 8'($urandom_range(0, 255)), draw_gap(burst), 1'b0, '0);
        else if (r < 90 && held_slots.size() != 0)
          issue_free_held(draw_gap(burst));
        else if (r < 95)
          // stray free: double free or slot outside the pool
          issue(KIND_FREE, 8'($urandom_range(0, 255)), draw_gap(burst), 1'b0, '0);
        else if (r < 98)
          issue(KIND_NOP, 8'($urandom_range(0, 255)), draw_gap(burst), 1'b0, '0);
        else
          issue(KIND_INIT, 8'($urandom_range(0, 255)), draw_gap(burst), 1'b0, '0);
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d commands: %0d init, %0d alloc (%0d out of memory), %0d free, %0d no-op",
             n_init + n_alloc + n_free + n_nop, n_init, n_alloc, n_oom, n_free, n_nop);
    $display("across %0d element_count writes; %0d mismatching beats",
             n_cfg, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/fsla_pkg.sv
hw/rtl/fsla_link_ram.sv
hw/rtl/free_list_slot_allocator.sv
tb/sv/free_list_slot_allocator_test.sv
